// File: sv/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types, constants and helpers of the page frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int ADDR_W     = 27;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = 6;
  localparam int CFG_W      = 16;
  localparam int LWORDS_W   = CFG_W - BIT_W;
  localparam int ADDR_PAGES = 1 << PAGE_W;

  localparam int          MAP_PAGES_DEF = 32768;
  localparam logic [CFG_W-1:0] CFG_RESET = 16'd32768;

  typedef enum logic [1:0] {
    OP_ALLOC_ANY  = 2'd0,
    OP_ALLOC_SPEC = 2'd1,
    OP_FREE       = 2'd2,
    OP_CHECK      = 2'd3
  } pfa_op_e;

  typedef struct packed {
    pfa_op_e           operation;
    logic [ADDR_W-1:0] page_address;
  } pfa_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    logic              was_taken;
    logic              no_free_page;
    logic              out_of_range;
  } pfa_rsp_t;

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: sv/page_frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// Bitmap page frame allocator: one used bit per 4 KiB page, 64 pages a word.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_ready_o / in_data_i) carries one beat per
//   operation: allocate lowest free page, allocate a given page, free a page,
//   or check a page. Every request beat yields exactly one response beat on
//   out_valid_o / out_ready_i / out_data_o, in order.
//   Configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the
//   page count of the map; it is always ready and is meant to be written while
//   no request is in flight.
//   Flow: a request passes through accept, word lookup with memory read and
//   read-modify-write in turn; the next request is accepted only once the
//   previous one has left the read-modify-write step.
//   The free-word search runs on a flag per word and a flag per 64 words.
//   Reset: the bitmap memory is cleared by a sweep of one word per cycle
//   over MAP_PAGES/64 words (512 at the default size); requests wait meanwhile.
//   Stall: the response sits in an output register; a new request is still
//   accepted, and its write-back holds until the previous response is taken.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator
  import pfa_pkg::*;
#(
  parameter int MAP_PAGES = MAP_PAGES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pfa_req_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pfa_rsp_t         out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int NUM_WORDS = MAP_PAGES / WORD_BITS;
  localparam int WIDX      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int GROUPS    = (NUM_WORDS + WORD_BITS - 1) / WORD_BITS;
  localparam int GIDX      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CAP_PAGES = (MAP_PAGES < ADDR_PAGES) ? MAP_PAGES : ADDR_PAGES;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_FIND  = 4'b0100,
    S_MOD   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0]    cfg_q;
  logic [CFG_W-1:0]    cfg_masked;
  logic [CFG_W-1:0]    limit_pages;
  logic [LWORDS_W-1:0] limit_words;

  logic [WIDX-1:0]     clr_q;
  pfa_op_e             op_q;
  logic [PAGE_W-1:0]   page_q;
  logic [GIDX-1:0]     grp_q;
  logic                grp_any_q;
  logic [WIDX-1:0]     word_q, word_d;
  logic                found_q, found_d;
  logic                oor_q, oor_d;

  logic [GIDX-1:0]     grp;
  logic                grp_any;
  logic [WIDX-1:0]     srch_word;
  logic                srch_found;
  logic [WIDX+PAGE_W-1:0] page_word_ext;

  logic                 mem_we, mem_re;
  logic [WIDX-1:0]      mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata, rd_data;

  logic                 mod_fire;
  logic [BIT_W-1:0]     free_bit;
  logic [WORD_BITS-1:0] new_word;
  logic                 mod_we;
  logic [WIDX+BIT_W-1:0] grant_page;
  pfa_rsp_t             rsp;

  logic     out_valid_q;
  pfa_rsp_t out_data_q;

  // Effective page count: round down to whole words, cap to map and address.
  assign cfg_masked  = cfg_q & ~CFG_W'(WORD_BITS - 1);
  assign limit_pages = (cfg_masked > CFG_W'(CAP_PAGES)) ? CFG_W'(CAP_PAGES) : cfg_masked;
  assign limit_words = limit_pages[CFG_W-1:BIT_W];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  pfa_free_index #(
    .NUM_WORDS(NUM_WORDS),
    .WIDX     (WIDX),
    .GROUPS   (GROUPS),
    .GIDX     (GIDX)
  ) u_index (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .upd_en_i     (mod_fire && mod_we),
    .upd_word_i   (word_q),
    .upd_full_i   (&new_word),
    .limit_words_i(limit_words),
    .grp_o        (grp),
    .grp_any_o    (grp_any),
    .sel_grp_i    (grp_q),
    .word_o       (srch_word),
    .word_found_o (srch_found)
  );

  pfa_bitmap_ram #(
    .DEPTH(NUM_WORDS),
    .AW   (WIDX)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(word_d),
    .rdata_o(rd_data)
  );

  assign in_ready_o = (state_q == S_IDLE);

  // Lookup stage: pick the target word and flag out-of-range requests.
  assign page_word_ext = (WIDX + PAGE_W)'(page_q) >> BIT_W;

  always_comb begin
    if (op_q == OP_ALLOC_ANY) begin
      word_d  = srch_word;
      found_d = grp_any_q && srch_found;
      oor_d   = 1'b0;
    end else begin
      word_d  = page_word_ext[WIDX-1:0];
      found_d = 1'b0;
      oor_d   = (CFG_W'(page_q) >= limit_pages);
    end
  end

  assign mem_re = (state_q == S_FIND);

  // Modify stage: update the word read back and build the response.
  assign mod_fire   = (state_q == S_MOD) && (!out_valid_q || out_ready_i);
  assign free_bit   = lowest_set(~rd_data);
  assign grant_page = {word_q, free_bit};

  always_comb begin
    rsp      = '0;
    new_word = rd_data;
    mod_we   = 1'b0;
    case (op_q)
      OP_ALLOC_ANY: begin
        if (found_q) begin
          new_word = rd_data | (WORD_BITS'(1) << free_bit);
          mod_we   = 1'b1;
          rsp.granted_address = ADDR_W'({grant_page, {PAGE_SHIFT{1'b0}}});
        end else begin
          rsp.no_free_page = 1'b1;
        end
      end
      OP_ALLOC_SPEC: begin
        rsp.was_taken = !oor_q && rd_data[page_q[BIT_W-1:0]];
        new_word      = rd_data | (WORD_BITS'(1) << page_q[BIT_W-1:0]);
        mod_we        = !oor_q;
      end
      OP_FREE: begin
        new_word = rd_data & ~(WORD_BITS'(1) << page_q[BIT_W-1:0]);
        mod_we   = !oor_q;
      end
      OP_CHECK: begin
        rsp.was_taken = !oor_q && rd_data[page_q[BIT_W-1:0]];
      end
      default: begin
        rsp = '0;
      end
    endcase
    rsp.out_of_range = (op_q != OP_ALLOC_ANY) && oor_q;
  end

  // Memory write port: the clearing sweep after reset, else write-back.
  always_comb begin
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = mod_fire && mod_we;
      mem_waddr = word_q;
      mem_wdata = new_word;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == WIDX'(NUM_WORDS - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_FIND;
      S_FIND:  state_d = S_MOD;
      S_MOD:   if (mod_fire) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + WIDX'(1);
      end
    end
  end

  // Request and lookup registers; payload only, no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q      <= in_data_i.operation;
      page_q    <= in_data_i.page_address[ADDR_W-1:PAGE_SHIFT];
      grp_q     <= grp;
      grp_any_q <= grp_any;
    end
    if (state_q == S_FIND) begin
      word_q  <= word_d;
      found_q <= found_d;
      oor_q   <= oor_d;
    end
  end

  // Output register: load on write-back, drop on a taken beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (mod_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mod_fire) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Write-back holds while the previous response is still pending.
  a_mod_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD && out_valid_q && !out_ready_i) |=> (state_q == S_MOD))
    else $error("write-back left while output slot was busy");

  // The memory is written only by the sweep or by a write-back.
  a_mem_we_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || mod_fire))
    else $error("bitmap written outside sweep or write-back");

  // An out-of-range request never touches the bitmap.
  a_oor_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_fire && rsp.out_of_range) |-> !mem_we)
    else $error("out-of-range request modified the bitmap");

  // A failed allocation never carries a granted address.
  a_none_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.no_free_page) |-> (out_data_o.granted_address == '0))
    else $error("no free page reported with a granted address");

endmodule

// File: sv/pfa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// pfa_bitmap_ram
// Single write, single read port memory of used-bit words, registered read.
// ----------------------------------------------------------------------------
module pfa_bitmap_ram
  import pfa_pkg::*;
#(
  parameter int DEPTH = MAP_PAGES_DEF / WORD_BITS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: sv/pfa_free_index.sv
// ----------------------------------------------------------------------------
// pfa_free_index
// Full-word summary flags with a two level search for the lowest word that
// still has a free page.
// ----------------------------------------------------------------------------
module pfa_free_index
  import pfa_pkg::*;
#(
  parameter int NUM_WORDS = MAP_PAGES_DEF / WORD_BITS,
  parameter int WIDX      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
  parameter int GROUPS    = (NUM_WORDS + WORD_BITS - 1) / WORD_BITS,
  parameter int GIDX      = (GROUPS > 1) ? $clog2(GROUPS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                upd_en_i,
  input  logic [WIDX-1:0]     upd_word_i,
  input  logic                upd_full_i,
  input  logic [LWORDS_W-1:0] limit_words_i,
  output logic [GIDX-1:0]     grp_o,
  output logic                grp_any_o,
  input  logic [GIDX-1:0]     sel_grp_i,
  output logic [WIDX-1:0]     word_o,
  output logic                word_found_o
);

  logic [NUM_WORDS-1:0]           full_q;
  logic [GROUPS*WORD_BITS-1:0]    full_pad;
  logic [GROUPS-1:0]              avail;
  logic [WORD_BITS-1:0]           cand;
  logic [BIT_W-1:0]               cand_idx;
  logic [GIDX+BIT_W-1:0]          word_wide;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= '0;
    end else if (upd_en_i) begin
      full_q[upd_word_i] <= upd_full_i;
    end
  end

  // Words past the end of the map read as full.
  for (genvar i = 0; i < GROUPS * WORD_BITS; i++) begin : g_pad
    if (i < NUM_WORDS) begin : g_real
      assign full_pad[i] = full_q[i];
    end else begin : g_fill
      assign full_pad[i] = 1'b1;
    end
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      avail[g] = !(&full_pad[g*WORD_BITS +: WORD_BITS]) &&
                 ((g * WORD_BITS) < int'(limit_words_i));
    end
    grp_o = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (avail[g]) grp_o = GIDX'(g);
    end
    grp_any_o = |avail;
  end

  always_comb begin
    cand         = ~full_pad[{sel_grp_i, {BIT_W{1'b0}}} +: WORD_BITS];
    cand_idx     = lowest_set(cand);
    word_wide    = {sel_grp_i, cand_idx};
    word_found_o = (|cand) && (int'(word_wide) < int'(limit_words_i));
    word_o       = word_wide[WIDX-1:0];
  end

endmodule
